>>> design/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants of the least prime factor sieve unit: request and
// result structs, opcodes, register map and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfs_pkg;

  // fixed field widths
  localparam int IDX_W    = 17;
  localparam int FACTOR_W = 17;
  localparam int COUNT_W  = 14;
  localparam int LIMIT_W  = 17;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_LIMIT = 1'b0;   // word index of sieve_limit
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

  // sieve constants: every entry starts at two, the walk steps over odd numbers
  localparam int ENTRY_INIT = 2;
  localparam int ODD_STEP   = 2;

  // opcodes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] query_index;
  } req_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor_value;
    logic [COUNT_W-1:0]  prime_count;
    logic                valid_res;
  } res_t;

endpackage

`default_nettype wire

>>> design/lpfs_ram.sv
// ----------------------------------------------------------------------------
// lpfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/lpfs_engine.sv
// ----------------------------------------------------------------------------
// lpfs_engine
// Sieve sequencer: clears the odd-entry factor table, walks odd x, lists
// primes and marks x times each listed prime through one shared multiplier.
// Also serves single-entry table lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_engine #(
  parameter int MAX_LIMIT   = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire lpfs_pkg::req_t                   req_i,
  input  wire logic [$clog2(MAX_LIMIT+1)-1:0]   limit_i,
  output logic                                  busy_o,
  output logic                                  res_valid_o,
  output lpfs_pkg::res_t                        res_o
);

  import lpfs_pkg::*;

  localparam int LW        = $clog2(MAX_LIMIT + 1);
  localparam int TW        = $clog2(MAX_LIMIT);
  localparam int ODD_DEPTH = (MAX_LIMIT + 1) / 2;
  localparam int TAW       = $clog2(ODD_DEPTH);
  localparam int CW        = $clog2(PRIME_SLOTS + 1);
  localparam int SAW       = $clog2(PRIME_SLOTS);
  localparam int PW        = TW + LW;
  localparam int QW        = (LW > IDX_W) ? LW : IDX_W;
  localparam int FXW       = (QW > FACTOR_W) ? QW : FACTOR_W;
  localparam int CXW       = (CW > COUNT_W) ? CW : COUNT_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_NEXT   = 4'd2;
  localparam logic [3:0] S_VISIT  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_PRD    = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_QRES   = 4'd8;

  logic [3:0]       state_q, state_d;
  logic             ready_q, ready_d;
  logic [LW-1:0]    built_q, built_d;
  logic [CW-1:0]    count_q, count_d;
  logic             res_valid_q, res_valid_d;

  logic [LW-1:0]    n_q, n_d;
  logic [LW-1:0]    x_q, x_d;
  logic [TAW-1:0]   clr_q, clr_d;
  logic [CW-1:0]    i_q, i_d;
  logic [TW-1:0]    cur_q, cur_d;
  logic [TW-1:0]    p_q, p_d;
  logic [PW-1:0]    prod_q, prod_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  res_t             res_q, res_d;

  logic             tab_we;
  logic [TAW-1:0]   tab_waddr, tab_raddr;
  logic [TW-1:0]    tab_wdata, tab_rdata;
  logic             st_we;
  logic [SAW-1:0]   st_waddr, st_raddr;
  logic [TW-1:0]    st_wdata, st_rdata;

  logic [LW-1:0]    n_m1;
  logic [TAW-1:0]   clr_end;
  logic [LW:0]      x_plus2;
  logic             last_x;
  logic             is_prime;
  logic             store_room;
  logic [QW-1:0]    qidx_ext, idx_ext;
  logic             q_valid;
  logic             q_is_two;
  logic [FXW-1:0]   fac_ext;
  logic [CXW-1:0]   cnt_ext;

  // factor table over odd numbers only: entry k holds odd number 2k+1
  lpfs_ram #(
    .Width (TW),
    .Depth (ODD_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // list of primes found, slot zero stands for two and is never read
  lpfs_ram #(
    .Width (TW),
    .Depth (PRIME_SLOTS)
  ) u_primes (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // loop bounds and compares
  assign n_m1       = n_q - LW'(1);
  assign clr_end    = n_m1[TAW:1];
  assign x_plus2    = {1'b0, x_q} + (LW+1)'(ODD_STEP);
  assign last_x     = x_plus2 > {1'b0, n_q};
  assign is_prime   = tab_rdata == TW'(ENTRY_INIT);
  assign store_room = count_q < CW'(PRIME_SLOTS);

  // lookup result
  assign qidx_ext = QW'(req_i.query_index);
  assign idx_ext  = QW'(idx_q);
  assign q_valid  = ready_q && (idx_ext <= QW'(built_q));
  assign q_is_two = !idx_q[0] || (idx_q == IDX_W'(1));
  assign cnt_ext  = CXW'(count_q);

  always_comb begin
    if (!q_valid) begin
      fac_ext = '0;
    end else if (q_is_two) begin
      fac_ext = FXW'(ENTRY_INIT);
    end else begin
      fac_ext = FXW'(tab_rdata);
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    built_d     = built_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    n_d         = n_q;
    x_d         = x_q;
    clr_d       = clr_q;
    i_d         = i_q;
    cur_d       = cur_q;
    p_d         = p_q;
    prod_d      = prod_q;
    idx_d       = idx_q;
    res_d       = res_q;

    tab_we    = 1'b0;
    tab_waddr = clr_q;
    tab_wdata = TW'(ENTRY_INIT);
    tab_raddr = x_q[TAW:1];
    st_we     = 1'b0;
    st_waddr  = count_q[SAW-1:0];
    st_wdata  = x_q[TW-1:0];
    st_raddr  = i_q[SAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        tab_raddr = qidx_ext[TAW:1];
        if (start_i) begin
          if (req_i.op == OP_QUERY) begin
            idx_d   = req_i.query_index;
            state_d = S_QRES;
          end else begin
            n_d     = limit_i;
            count_d = CW'(1);
            clr_d   = '0;
            x_d     = LW'(1);
            state_d = S_CLEAR;
          end
        end
      end

      // reset every odd entry up to the limit to two
      S_CLEAR: begin
        tab_we = 1'b1;
        clr_d  = clr_q + TAW'(1);
        if (clr_q == clr_end) begin
          state_d = S_NEXT;
        end
      end

      // step to the next odd x or finish the build
      S_NEXT: begin
        if (last_x) begin
          ready_d                  = 1'b1;
          built_d                  = n_q;
          res_valid_d              = 1'b1;
          res_d.factor_value       = '0;
          res_d.prime_count        = cnt_ext[COUNT_W-1:0];
          res_d.valid_res          = 1'b1;
          state_d                  = S_IDLE;
        end else begin
          x_d     = x_plus2[LW-1:0];
          state_d = S_VISIT;
        end
      end

      S_VISIT: begin
        state_d = S_DECIDE;
      end

      // an entry still at two marks a prime
      S_DECIDE: begin
        i_d     = CW'(1);
        state_d = S_PRD;
        if (is_prime) begin
          tab_we    = 1'b1;
          tab_waddr = x_q[TAW:1];
          tab_wdata = x_q[TW-1:0];
          cur_d     = x_q[TW-1:0];
          if (store_room) begin
            st_we   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end else begin
          cur_d = tab_rdata;
        end
      end

      // fetch the next listed odd prime
      S_PRD: begin
        if (i_q < count_q) begin
          state_d = S_MUL;
        end else begin
          state_d = S_NEXT;
        end
      end

      // shared multiplier
      S_MUL: begin
        p_d     = st_rdata;
        prod_d  = PW'(st_rdata) * PW'(x_q);
        state_d = S_CHK;
      end

      // mark x times p unless p passes the factor of x or the product the limit
      S_CHK: begin
        if ((p_q > cur_q) || (prod_q > PW'(n_q))) begin
          state_d = S_NEXT;
        end else begin
          tab_we    = 1'b1;
          tab_waddr = prod_q[TAW:1];
          tab_wdata = p_q;
          i_d       = i_q + CW'(1);
          state_d   = S_PRD;
        end
      end

      S_QRES: begin
        res_valid_d        = 1'b1;
        res_d.factor_value = fac_ext[FACTOR_W-1:0];
        res_d.prime_count  = cnt_ext[COUNT_W-1:0];
        res_d.valid_res    = q_valid;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      built_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      built_q     <= built_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    x_q    <= x_d;
    clr_q  <= clr_d;
    i_q    <= i_d;
    cur_q  <= cur_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> design/least_prime_factor_sieve_unit.sv
// Query: accepted at start, looked up through the registered table read; no new
//   query is taken until the engine leaves its result state.
// Build: clears the table, then visits each odd number from 3 up to L and walks
//   the listed primes, marking each product until a bound stops the walk, with
//   one closing step before the result strobe.
// Reset: asynchronous, active low; limit returns to 65536 and the table reads as
//   not built. No clearing pass after reset; the results cannot be stalled.
// ----------------------------------------------------------------------------
// least_prime_factor_sieve_unit
// Linear sieve of least prime factors with an APB limit register, a command
// style request port and a one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module least_prime_factor_sieve_unit #(
  parameter int MAX_LIMIT   = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request port
  input  wire logic                          start,
  output logic                               busy,
  input  wire lpfs_pkg::req_t                req_i,
  // result port
  output logic                               res_valid_o,
  output lpfs_pkg::res_t                     res_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lpfs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lpfs_pkg::APB_DW-1:0]   pwdata,
  output logic      [lpfs_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  import lpfs_pkg::*;

  localparam int LW  = $clog2(MAX_LIMIT + 1);
  localparam int CLW = (LW > LIMIT_W) ? LW : LIMIT_W;

  logic [LIMIT_W-1:0] limit_q;
  logic               wr_en;
  logic               sel_limit;
  logic [CLW-1:0]     lim_ext;
  logic [CLW-1:0]     lim_clamped;
  logic [LW-1:0]      lim_eff;
  logic               accept;
  logic               eng_busy;

  // register access
  assign pready    = 1'b1;
  assign sel_limit = paddr[APB_AW-1] == REG_LIMIT;
  assign wr_en     = psel && penable && pwrite && pready;
  assign prdata    = sel_limit ? APB_DW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_en && sel_limit) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // clamp the limit to the supported range
  assign lim_ext = CLW'(limit_q);
  always_comb begin
    if (lim_ext < CLW'(ENTRY_INIT)) begin
      lim_clamped = CLW'(ENTRY_INIT);
    end else if (lim_ext > CLW'(MAX_LIMIT)) begin
      lim_clamped = CLW'(MAX_LIMIT);
    end else begin
      lim_clamped = lim_ext;
    end
  end
  assign lim_eff = lim_clamped[LW-1:0];

  // request handshake
  assign busy   = eng_busy;
  assign accept = start && !eng_busy;

  lpfs_engine #(
    .MAX_LIMIT   (MAX_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .req_i       (req_i),
    .limit_i     (lim_eff),
    .busy_o      (eng_busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("engine not busy after accepted request");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.valid_res) |-> (res_o.factor_value == '0))
    else $error("invalid result carries a factor");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a request in flight");

endmodule

`default_nettype wire
